// File: rtl/rlt_pkg.sv
`default_nettype none
package rlt_pkg;

	localparam int NUM_RESOURCES = 8;
	localparam int IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

	localparam int OP_W    = 3;
	localparam int ID_W    = 8;
	localparam int RIDX_W  = 8;
	localparam int WORD_W  = 64;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 8;

	// opcodes
	localparam logic [OP_W-1:0] OP_CONNECT    = 3'd0;
	localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd1;
	localparam logic [OP_W-1:0] OP_TAKE       = 3'd2;
	localparam logic [OP_W-1:0] OP_RETURN     = 3'd3;

	// reply status codes
	localparam logic [STAT_W-1:0] ST_GRANTED     = 3'd0;
	localparam logic [STAT_W-1:0] ST_BUSY        = 3'd1;
	localparam logic [STAT_W-1:0] ST_SET         = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_RESOURCE = 3'd3;
	localparam logic [STAT_W-1:0] ST_NO_ACTION   = 3'd4;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
	} tbl_rd_req_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [ID_W-1:0]   owner;
		logic [WORD_W-1:0] value;
	} tbl_wr_req_t;

	typedef struct packed {
		logic [ID_W-1:0]   owner;
		logic [WORD_W-1:0] value;
	} tbl_rd_data_t;

endpackage
`default_nettype wire

// File: rtl/rlt_req_if.sv
`default_nettype none
interface rlt_req_if;
	logic                              valid;
	logic                              ready;
	logic [rlt_pkg::OP_W-1:0]          opcode;
	logic [rlt_pkg::ID_W-1:0]          requester_id;
	logic [rlt_pkg::RIDX_W-1:0]        resource_index;
	logic signed [rlt_pkg::WORD_W-1:0] return_value;

	modport source (
		output valid, opcode, requester_id, resource_index, return_value,
		input  ready
	);
	modport sink (
		input  valid, opcode, requester_id, resource_index, return_value,
		output ready
	);
endinterface
`default_nettype wire

// File: rtl/rlt_rsp_if.sv
`default_nettype none
interface rlt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              reply_valid;
	logic [rlt_pkg::STAT_W-1:0]        reply_status;
	logic signed [rlt_pkg::WORD_W-1:0] read_value;
	logic                              session_open;

	modport source (
		output valid, reply_valid, reply_status, read_value, session_open,
		input  ready
	);
	modport sink (
		input  valid, reply_valid, reply_status, read_value, session_open,
		output ready
	);
endinterface
`default_nettype wire

// File: rtl/rlt_table_mem.sv
`default_nettype none
module rlt_table_mem (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rlt_pkg::tbl_rd_req_t  rd_req,
	input  wire rlt_pkg::tbl_wr_req_t  wr_req,
	output rlt_pkg::tbl_rd_data_t      rd_data
);

	logic [rlt_pkg::ID_W-1:0]   owner_mem [rlt_pkg::NUM_RESOURCES];
	logic [rlt_pkg::WORD_W-1:0] value_mem [rlt_pkg::NUM_RESOURCES];
	logic [rlt_pkg::NUM_RESOURCES-1:0] written_q;

	logic [rlt_pkg::ID_W-1:0]   owner_rd_q;
	logic [rlt_pkg::WORD_W-1:0] value_rd_q;
	logic                       hit_q;

	// storage, no reset
	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			owner_mem[wr_req.addr] <= wr_req.owner;
			value_mem[wr_req.addr] <= wr_req.value;
		end
		if (rd_req.en) begin
			owner_rd_q <= owner_mem[rd_req.addr];
			value_rd_q <= value_mem[rd_req.addr];
		end
	end

	// per-entry written flags; unwritten entries read as zero (free, zero word)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (wr_req.en) begin
				written_q[wr_req.addr] <= 1'b1;
			end
			if (rd_req.en) begin
				hit_q <= written_q[rd_req.addr];
			end
		end
	end

	assign rd_data.owner = hit_q ? owner_rd_q : '0;
	assign rd_data.value = hit_q ? value_rd_q : '0;

endmodule
`default_nettype wire

// File: rtl/resource_lock_table_core.sv
`default_nettype none
// Resource lock table: a small table of shared resources, each with a 64-bit data
// word and an owner id (0 = free).
// Channels: req (sink) carries one request per transfer: opcode, requester_id,
// resource_index, return_value. rsp (source) carries exactly one result per
// request: reply_valid, reply_status, read_value, session_open. Connect and
// disconnect results carry reply_valid = 0 and are still transferred.
// The request is captured and the table read at its transfer; the lookup state then
// loads the result into the output register, from which it is transferred out.
// Only one request is in flight at a time: none is taken until the lookup state is
// done. The table memory is read at the transfer edge and written back at the next
// edge, so read and write of one entry never overlap.
// The result sits in an output register; the next request is taken in the same
// cycle that the pending result is transferred out.
// Reset (arst_n low, asynchronous): all entries free with a zero word (per-entry
// written flags), client count zero, session_open output low. No sweep is needed.
// Receiver stall: while rsp.ready is low the result holds and req.ready stays
// low once the block has a result waiting and no request in flight.
module resource_lock_table_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rlt_req_if.sink     req,
	rlt_rsp_if.source   rsp
);

	typedef enum logic {
		S_IDLE,
		S_LOOKUP
	} state_t;

	state_t state_q;

	// request captured at transfer
	logic [rlt_pkg::OP_W-1:0]   op_q;
	logic [rlt_pkg::ID_W-1:0]   who_q;
	logic [rlt_pkg::WORD_W-1:0] word_q;
	logic [rlt_pkg::IDX_W-1:0]  idx_q;
	logic                       in_range_q;

	// session tracking
	logic [rlt_pkg::COUNT_W-1:0] count_q;
	logic                        ever_q;

	// output register
	logic                        rsp_valid_q;
	logic                        reply_valid_q;
	logic [rlt_pkg::STAT_W-1:0]  reply_status_q;
	logic [rlt_pkg::WORD_W-1:0]  read_value_q;
	logic                        session_open_q;

	logic accept;
	logic in_range;

	rlt_pkg::tbl_rd_req_t  rd_req;
	rlt_pkg::tbl_wr_req_t  wr_req;
	rlt_pkg::tbl_rd_data_t rd_data;

	// next-state values computed in the lookup cycle
	logic                        valid_nxt;
	logic [rlt_pkg::STAT_W-1:0]  status_nxt;
	logic [rlt_pkg::WORD_W-1:0]  read_nxt;
	logic [rlt_pkg::COUNT_W-1:0] count_nxt;
	logic                        ever_nxt;
	logic                        session_nxt;
	logic                        wr_en_nxt;
	logic [rlt_pkg::ID_W-1:0]    wr_owner_nxt;
	logic [rlt_pkg::WORD_W-1:0]  wr_value_nxt;

	// take a request only when idle and the output slot is free by the next edge
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign in_range = {1'b0, req.resource_index} < (rlt_pkg::RIDX_W + 1)'(rlt_pkg::NUM_RESOURCES);

	assign rd_req.en   = accept;
	assign rd_req.addr = req.resource_index[rlt_pkg::IDX_W-1:0];

	rlt_table_mem u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_req  (rd_req),
		.wr_req  (wr_req),
		.rd_data (rd_data)
	);

	// read-modify-write decision on the entry read in the previous cycle
	always_comb begin
		valid_nxt    = 1'b1;
		status_nxt   = rlt_pkg::ST_GRANTED;
		read_nxt     = '0;
		count_nxt    = count_q;
		ever_nxt     = ever_q;
		wr_en_nxt    = 1'b0;
		wr_owner_nxt = rd_data.owner;
		wr_value_nxt = rd_data.value;
		case (op_q)
			rlt_pkg::OP_CONNECT: begin
				ever_nxt  = 1'b1;
				valid_nxt = 1'b0;
				if (count_q != {rlt_pkg::COUNT_W{1'b1}}) begin
					count_nxt = count_q + 1'b1;
				end
			end
			rlt_pkg::OP_DISCONNECT: begin
				valid_nxt = 1'b0;
				if (count_q != '0) begin
					count_nxt = count_q - 1'b1;
				end
			end
			rlt_pkg::OP_TAKE: begin
				if (!in_range_q) begin
					status_nxt = rlt_pkg::ST_NO_RESOURCE;
				end else if (rd_data.owner != '0) begin
					status_nxt = rlt_pkg::ST_BUSY;
				end else begin
					// word is written back unchanged, only the owner moves
					status_nxt   = rlt_pkg::ST_GRANTED;
					read_nxt     = rd_data.value;
					wr_en_nxt    = 1'b1;
					wr_owner_nxt = who_q;
				end
			end
			rlt_pkg::OP_RETURN: begin
				if (!in_range_q) begin
					status_nxt = rlt_pkg::ST_NO_RESOURCE;
				end else if (rd_data.owner != who_q) begin
					status_nxt = rlt_pkg::ST_BUSY;
				end else begin
					status_nxt   = rlt_pkg::ST_SET;
					wr_en_nxt    = 1'b1;
					wr_owner_nxt = '0;
					wr_value_nxt = word_q;
				end
			end
			default: begin
				status_nxt = rlt_pkg::ST_NO_ACTION;
			end
		endcase
		session_nxt = !ever_nxt || (count_nxt != '0);
	end

	assign wr_req.en    = (state_q == S_LOOKUP) && wr_en_nxt;
	assign wr_req.addr  = idx_q;
	assign wr_req.owner = wr_owner_nxt;
	assign wr_req.value = wr_value_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= '0;
			who_q          <= '0;
			word_q         <= '0;
			idx_q          <= '0;
			in_range_q     <= 1'b0;
			count_q        <= '0;
			ever_q         <= 1'b0;
			rsp_valid_q    <= 1'b0;
			reply_valid_q  <= 1'b0;
			reply_status_q <= '0;
			read_value_q   <= '0;
			session_open_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rsp_valid_q && rsp.ready) begin
						rsp_valid_q <= 1'b0;
					end
					if (accept) begin
						op_q       <= req.opcode;
						who_q      <= req.requester_id;
						word_q     <= req.return_value;
						idx_q      <= req.resource_index[rlt_pkg::IDX_W-1:0];
						in_range_q <= in_range;
						state_q    <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					// output slot is known free here
					rsp_valid_q    <= 1'b1;
					reply_valid_q  <= valid_nxt;
					reply_status_q <= status_nxt;
					read_value_q   <= read_nxt;
					session_open_q <= session_nxt;
					count_q        <= count_nxt;
					ever_q         <= ever_nxt;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.reply_valid  = reply_valid_q;
	assign rsp.reply_status = reply_status_q;
	assign rsp.read_value   = read_value_q;
	assign rsp.session_open = session_open_q;

endmodule
`default_nettype wire
